/* rtl/head_tail_capture_buffer_unit_defines.svh */
// Assertion macros shared by the capture buffer modules.
`ifndef HEAD_TAIL_CAPTURE_BUFFER_UNIT_DEFINES_SVH
`define HEAD_TAIL_CAPTURE_BUFFER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset.
`define HTCB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: check failed");

// Next-cycle implication.
`define HTCB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: check failed");

`endif

/* rtl/htcb_pkg.sv */
// Shared constants, types and codes of the head/tail capture buffer.
package htcb_pkg;

	localparam int MAX_BYTES  = 4096;
	localparam int HEAD_DEPTH = MAX_BYTES / 2;
	localparam int TAIL_DEPTH = MAX_BYTES - MAX_BYTES / 2;
	localparam int HEAD_AW    = $clog2(HEAD_DEPTH);
	localparam int TAIL_AW    = $clog2(TAIL_DEPTH);
	localparam int CNT_W      = 12;
	localparam int LIMIT_W    = 13;
	localparam int POS_W      = 12;
	localparam int BYTE_W     = 8;
	localparam int TOTAL_W    = 64;

	localparam logic MODE_APPEND = 1'b0;
	localparam logic MODE_READ   = 1'b1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_CLASS = 5'b00010,
		ST_ADDR  = 5'b00100,
		ST_MEM   = 5'b01000,
		ST_WAIT  = 5'b10000
	} state_t;

	typedef struct packed {
		logic load;
		logic classify;
		logic addr;
		logic mem;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic mode;
		logic out_free;
	} status_t;

endpackage

/* rtl/htcb_in_if.sv */
// Request channel: append or read item with valid/ready handshake.
interface htcb_in_if;
	logic                            valid;
	logic                            ready;
	logic                            mode;
	logic [htcb_pkg::BYTE_W-1:0]     data_byte;
	logic [htcb_pkg::POS_W-1:0]      position;

	modport source (output valid, output mode, output data_byte, output position,
		input ready);
	modport sink (input valid, input mode, input data_byte, input position,
		output ready);
endinterface

/* rtl/htcb_out_if.sv */
// Response channel: one result item per request item.
interface htcb_out_if;
	logic                            valid;
	logic                            ready;
	logic [htcb_pkg::BYTE_W-1:0]     read_byte;
	logic                            read_valid;
	logic [htcb_pkg::LIMIT_W-1:0]    stored_length;
	logic                            truncated;
	logic [htcb_pkg::TOTAL_W-1:0]    produced_total;

	modport source (output valid, output read_byte, output read_valid,
		output stored_length, output truncated, output produced_total, input ready);
	modport sink (input valid, input read_byte, input read_valid,
		input stored_length, input truncated, input produced_total, output ready);
endinterface

/* rtl/htcb_ram.sv */
// Generic single-port RAM with registered read data.
module htcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/htcb_ctrl.sv */
// Controller state machine sequencing one item through the datapath.
`include "head_tail_capture_buffer_unit_defines.svh"

module htcb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  htcb_pkg::status_t status,
	output htcb_pkg::cmd_t    cmd
);

	htcb_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= htcb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			htcb_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = htcb_pkg::ST_CLASS;
				end
			end
			htcb_pkg::ST_CLASS: begin
				cmd.classify = 1'b1;
				// appends need no ring address
				state_d = (status.mode == htcb_pkg::MODE_READ) ? htcb_pkg::ST_ADDR
					: htcb_pkg::ST_MEM;
			end
			htcb_pkg::ST_ADDR: begin
				cmd.addr = 1'b1;
				state_d  = htcb_pkg::ST_MEM;
			end
			htcb_pkg::ST_MEM: begin
				cmd.mem = 1'b1;
				state_d = htcb_pkg::ST_WAIT;
			end
			htcb_pkg::ST_WAIT: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = htcb_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = htcb_pkg::ST_IDLE;
			end
		endcase
	end

	`HTCB_ASSERT_NEXT(a_load_to_class, clk, arst_n, cmd.load, state_q == htcb_pkg::ST_CLASS)
	`HTCB_ASSERT_NEXT(a_emit_to_idle, clk, arst_n, cmd.emit, in_ready)
	`HTCB_ASSERT_NOW(a_state_onehot, clk, arst_n, 1'b1, $onehot(state_q))

endmodule

/* rtl/htcb_dp.sv */
// Datapath: counters, head and tail stores, address arithmetic, result register.
`include "head_tail_capture_buffer_unit_defines.svh"

module htcb_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  htcb_pkg::cmd_t                 cmd,
	output htcb_pkg::status_t              status,
	input  logic                           cfg_wr_en,
	input  logic [htcb_pkg::LIMIT_W-1:0]   cfg_wr_data,
	htcb_in_if.sink                        req,
	htcb_out_if.source                     rsp
);

	localparam int LW = htcb_pkg::LIMIT_W;
	localparam int CW = htcb_pkg::CNT_W;

	// capacity and occupancy
	logic [CW-1:0]                     head_cap_q, tail_cap_q;
	logic [CW-1:0]                     head_count_q, tail_count_q;
	logic [htcb_pkg::TAIL_AW-1:0]      tail_start_q;
	logic [htcb_pkg::TOTAL_W-1:0]      produced_q;

	// item and intermediate results
	logic                              mode_q;
	logic [htcb_pkg::BYTE_W-1:0]       data_q;
	logic [htcb_pkg::POS_W-1:0]        pos_q;
	logic [CW-1:0]                     rel_q;
	logic                              hit_head_q, hit_tail_q;
	logic                              head_room_q, tail_room_q, tail_none_q;
	logic [LW-1:0]                     addr_sum_q;
	logic                              rd_valid_q, rd_head_q;

	// result register
	logic                              rsp_valid_q;
	logic [htcb_pkg::BYTE_W-1:0]       rsp_byte_q;
	logic                              rsp_rvalid_q;
	logic [LW-1:0]                     rsp_len_q;
	logic                              rsp_trunc_q;
	logic [htcb_pkg::TOTAL_W-1:0]      rsp_total_q;

	logic [LW-1:0]                     lim_sat;
	logic [CW-1:0]                     head_cap_new, tail_cap_new;
	logic [LW-1:0]                     tail_idx;
	logic [CW-1:0]                     start_inc;
	logic [LW-1:0]                     stored;
	logic                              trunc;

	logic                              head_we, head_re, tail_we, tail_re;
	logic [htcb_pkg::HEAD_AW-1:0]      head_addr;
	logic [htcb_pkg::TAIL_AW-1:0]      tail_addr;
	logic [htcb_pkg::BYTE_W-1:0]       head_rdata, tail_rdata;
	logic                              do_append, do_read;

	assign lim_sat = (cfg_wr_data > LW'(htcb_pkg::MAX_BYTES)) ? LW'(htcb_pkg::MAX_BYTES)
		: cfg_wr_data;
	assign head_cap_new = CW'(lim_sat >> 1);
	assign tail_cap_new = CW'(lim_sat - LW'(head_cap_new));

	assign tail_idx = (addr_sum_q >= LW'(tail_cap_q)) ? addr_sum_q - LW'(tail_cap_q)
		: addr_sum_q;
	assign start_inc = CW'(tail_start_q) + CW'(1);

	assign stored = LW'(head_count_q) + LW'(tail_count_q);
	assign trunc  = (|produced_q[htcb_pkg::TOTAL_W-1:LW]) || (produced_q[LW-1:0] > stored);

	assign do_append = cmd.mem && (mode_q == htcb_pkg::MODE_APPEND);
	assign do_read   = cmd.mem && (mode_q == htcb_pkg::MODE_READ);

	always_comb begin
		head_we   = 1'b0;
		head_re   = 1'b0;
		tail_we   = 1'b0;
		tail_re   = 1'b0;
		head_addr = pos_q[htcb_pkg::HEAD_AW-1:0];
		tail_addr = tail_idx[htcb_pkg::TAIL_AW-1:0];
		if (do_append) begin
			if (head_room_q) begin
				head_we   = 1'b1;
				head_addr = head_count_q[htcb_pkg::HEAD_AW-1:0];
			end else if (!tail_none_q) begin
				tail_we   = 1'b1;
				tail_addr = tail_room_q ? tail_count_q[htcb_pkg::TAIL_AW-1:0] : tail_start_q;
			end
		end else if (do_read) begin
			head_re = hit_head_q;
			tail_re = !hit_head_q && hit_tail_q;
		end
	end

	// control state: occupancy, capacity, saturating count, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_cap_q   <= CW'(htcb_pkg::HEAD_DEPTH);
			tail_cap_q   <= CW'(htcb_pkg::TAIL_DEPTH);
			head_count_q <= '0;
			tail_count_q <= '0;
			tail_start_q <= '0;
			produced_q   <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				head_cap_q   <= head_cap_new;
				tail_cap_q   <= tail_cap_new;
				head_count_q <= '0;
				tail_count_q <= '0;
				tail_start_q <= '0;
				produced_q   <= '0;
			end else if (do_append) begin
				if (produced_q != '1) begin
					produced_q <= produced_q + htcb_pkg::TOTAL_W'(1);
				end
				if (head_room_q) begin
					head_count_q <= head_count_q + CW'(1);
				end else if (!tail_none_q) begin
					if (tail_room_q) begin
						tail_count_q <= tail_count_q + CW'(1);
					end else if (start_inc >= tail_cap_q) begin
						tail_start_q <= '0;
					end else begin
						tail_start_q <= start_inc[htcb_pkg::TAIL_AW-1:0];
					end
				end
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req.mode;
			data_q <= req.data_byte;
			pos_q  <= req.position;
		end
		if (cmd.classify) begin
			hit_head_q  <= CW'(pos_q) < head_count_q;
			rel_q       <= CW'(pos_q) - head_count_q;
			head_room_q <= head_count_q < head_cap_q;
			tail_room_q <= tail_count_q < tail_cap_q;
			tail_none_q <= tail_cap_q == '0;
		end
		if (cmd.addr) begin
			hit_tail_q <= rel_q < tail_count_q;
			addr_sum_q <= LW'(tail_start_q) + LW'(rel_q);
		end
		if (cmd.mem) begin
			rd_valid_q <= do_read && (hit_head_q || hit_tail_q);
			rd_head_q  <= hit_head_q;
		end
		if (cmd.emit) begin
			rsp_byte_q   <= !rd_valid_q ? '0 : (rd_head_q ? head_rdata : tail_rdata);
			rsp_rvalid_q <= rd_valid_q;
			rsp_len_q    <= stored;
			rsp_trunc_q  <= trunc;
			rsp_total_q  <= produced_q;
		end
	end

	htcb_ram #(
		.WIDTH (htcb_pkg::BYTE_W),
		.DEPTH (htcb_pkg::HEAD_DEPTH)
	) u_head_ram (
		.clk   (clk),
		.we    (head_we),
		.re    (head_re),
		.addr  (head_addr),
		.wdata (data_q),
		.rdata (head_rdata)
	);

	htcb_ram #(
		.WIDTH (htcb_pkg::BYTE_W),
		.DEPTH (htcb_pkg::TAIL_DEPTH)
	) u_tail_ram (
		.clk   (clk),
		.we    (tail_we),
		.re    (tail_re),
		.addr  (tail_addr),
		.wdata (data_q),
		.rdata (tail_rdata)
	);

	assign status.mode     = mode_q;
	assign status.out_free = !rsp_valid_q || rsp.ready;

	assign rsp.valid          = rsp_valid_q;
	assign rsp.read_byte      = rsp_byte_q;
	assign rsp.read_valid     = rsp_rvalid_q;
	assign rsp.stored_length  = rsp_len_q;
	assign rsp.truncated      = rsp_trunc_q;
	assign rsp.produced_total = rsp_total_q;

	`HTCB_ASSERT_NOW(a_head_bound, clk, arst_n, 1'b1, head_count_q <= head_cap_q)
	`HTCB_ASSERT_NOW(a_ring_full, clk, arst_n, tail_start_q != '0, tail_count_q == tail_cap_q)
	`HTCB_ASSERT_NEXT(a_cfg_clears, clk, arst_n, cfg_wr_en, produced_q == '0 && stored == '0)

endmodule

/* rtl/head_tail_capture_buffer_unit.sv */
// Top level of the head/tail capture buffer: controller, datapath and port wiring.
//
// Usage
//   req  : request items. mode 0 appends data_byte; mode 1 reads the byte at
//          position of the linearised capture (head bytes, then the tail ring
//          oldest to newest).
//   rsp  : exactly one result item per request: read_byte, read_valid,
//          stored_length, truncated (bytes have been lost) and produced_total.
//   cfg  : cfg_wr_en/cfg_wr_data write total_limit (capped at 4096). A write
//          empties the capture and zeroes the count; issue it only when idle.
// Sequencing
//   One item at a time. After acceptance an append goes through classify and
//   store access to rsp.valid; a read goes through classify, ring address add,
//   store access and registered read data. req.ready rises with rsp.valid, so
//   the next item is taken only once the last result is presented.
// Reset (arst_n, asynchronous)
//   Counters clear at once; limit returns to 4096. The stores are not cleared:
//   an entry is only ever read after it has been written. No clearing pass.
// Back-pressure
//   If rsp.ready is low, the finished item parks in the wait state until the
//   output register frees; req.ready stays low meanwhile, nothing is dropped.
module head_tail_capture_buffer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	htcb_in_if.sink                       req,
	htcb_out_if.source                    rsp,
	input  logic                          cfg_wr_en,
	input  logic [htcb_pkg::LIMIT_W-1:0]  cfg_wr_data
);

	htcb_pkg::cmd_t    cmd;
	htcb_pkg::status_t status;
	logic              in_ready;

	// item sequencing
	htcb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	// storage, counters and result register
	htcb_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.status      (status),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.rsp         (rsp)
	);

	assign req.ready = in_ready;

endmodule

/* sim/testbench.sv */
// Self-checking testbench for the head/tail capture buffer unit.
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RANDOM_ITEMS = 1460;
	localparam int unsigned SETTLE_CYCLES = 20;
	localparam int unsigned HOLD_CYCLES = 400;    // one long receiver hold-off
	localparam int unsigned CYCLE_LIMIT = 1000000;

	// one request item and one result item, at the port widths
	typedef struct packed {
		logic                        mode;
		logic [htcb_pkg::BYTE_W-1:0] data_byte;
		logic [htcb_pkg::POS_W-1:0]  position;
	} capture_req_t;

	typedef struct packed {
		logic [htcb_pkg::BYTE_W-1:0]  read_byte;
		logic                         read_valid;
		logic [htcb_pkg::LIMIT_W-1:0] stored_length;
		logic                         truncated;
		logic [htcb_pkg::TOTAL_W-1:0] produced_total;
	} capture_rsp_t;

	logic clk;
	logic arst_n;
	logic cfg_wr_en;
	logic [htcb_pkg::LIMIT_W-1:0] cfg_wr_data;

	htcb_in_if  req_ch ();
	htcb_out_if rsp_ch ();

	head_tail_capture_buffer_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Shadow of the capture: limit register, both stores and the counters.
	logic [htcb_pkg::LIMIT_W-1:0] limit_reg;
	logic [htcb_pkg::BYTE_W-1:0]  head_mem [htcb_pkg::HEAD_DEPTH];
	logic [htcb_pkg::BYTE_W-1:0]  tail_mem [htcb_pkg::TAIL_DEPTH];
	int unsigned                  head_cnt;
	int unsigned                  tail_cnt;
	int unsigned                  tail_oldest;   // ring slot of the oldest tail byte once full
	logic [htcb_pkg::TOTAL_W-1:0] produced_cnt;

	capture_req_t req_backlog [$];   // items not yet offered to the block
	capture_rsp_t rsp_due [$];       // results owed by the block, oldest first
	capture_req_t drv_item;
	capture_rsp_t want;
	int unsigned  drv_gap, drv_calm;
	int unsigned  rcv_stall, rcv_calm;
	int unsigned  accepted_cnt;
	int unsigned  err_cnt;
	int unsigned  cycle_cnt;
	logic         long_hold;

	// Applies one accepted item to the shadow capture, returns the result it owes.
	function automatic capture_rsp_t capture_apply(capture_req_t it);
		int unsigned lim, head_cap, tail_cap, ofs, idx;
		capture_rsp_t r;
		lim = (limit_reg > htcb_pkg::MAX_BYTES) ? htcb_pkg::MAX_BYTES : limit_reg;
		head_cap = lim / 2;
		tail_cap = lim - head_cap;
		r = '0;
		if (it.mode == htcb_pkg::MODE_APPEND) begin
			if (produced_cnt != '1)
				produced_cnt = produced_cnt + 1;
			if (head_cnt < head_cap) begin
				head_mem[head_cnt] = it.data_byte;
				head_cnt++;
			end else if (tail_cap != 0) begin
				if (tail_cnt < tail_cap) begin
					tail_mem[tail_cnt] = it.data_byte;
					tail_cnt++;
				end else begin
					// ring full: overwrite the oldest byte and move on
					tail_mem[tail_oldest] = it.data_byte;
					tail_oldest++;
					if (tail_oldest >= tail_cap)
						tail_oldest = 0;
				end
			end
		end else begin
			if (it.position < head_cnt) begin
				r.read_valid = 1'b1;
				r.read_byte = head_mem[it.position];
			end else begin
				ofs = it.position - head_cnt;
				if (ofs < tail_cnt) begin
					idx = tail_oldest + ofs;
					if (idx >= tail_cap)
						idx -= tail_cap;
					r.read_valid = 1'b1;
					r.read_byte = tail_mem[idx];
				end
			end
		end
		r.stored_length = htcb_pkg::LIMIT_W'(head_cnt + tail_cnt);
		r.truncated = produced_cnt > htcb_pkg::TOTAL_W'(head_cnt + tail_cnt);
		r.produced_total = produced_cnt;
		return r;
	endfunction

	// Idle length after a handshake: mostly none or short, now and then long,
	// with occasional calm stretches where no idling happens at all.
	function automatic int unsigned pick_gap(ref int unsigned calm);
		int unsigned roll;
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0)
			calm = $urandom_range(20, 80);
		roll = $urandom_range(0, 99);
		if (roll < 60)
			return 0;
		else if (roll < 90)
			return $urandom_range(1, 3);
		else if (roll < 97)
			return $urandom_range(4, 10);
		else
			return $urandom_range(20, 60);
	endfunction

	// Clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Sender: offers backlog items, holds valid while the block stalls and
	// predicts the result of every item the block takes.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
		end else if (!req_ch.valid || req_ch.ready) begin
			if (req_ch.valid) begin
				rsp_due.push_back(capture_apply(drv_item));
				accepted_cnt++;
				drv_gap = pick_gap(drv_calm);
			end
			if (drv_gap > 0) begin
				drv_gap--;
				req_ch.valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				drv_item = req_backlog.pop_front();
				req_ch.valid <= 1'b1;
				req_ch.mode <= drv_item.mode;
				req_ch.data_byte <= drv_item.data_byte;
				req_ch.position <= drv_item.position;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	// Receiver: checks every result against the oldest owed one, then stalls
	// at random; the long hold-off overrides everything else.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (rsp_due.size() == 0) begin
					$error("result item arrived with nothing owed");
					err_cnt++;
				end else begin
					want = rsp_due.pop_front();
					if (rsp_ch.read_byte !== want.read_byte) begin
						$error("read_byte: expected %0h, got %0h", want.read_byte,
							rsp_ch.read_byte);
						err_cnt++;
					end
					if (rsp_ch.read_valid !== want.read_valid) begin
						$error("read_valid: expected %0b, got %0b", want.read_valid,
							rsp_ch.read_valid);
						err_cnt++;
					end
					if (rsp_ch.stored_length !== want.stored_length) begin
						$error("stored_length: expected %0d, got %0d",
							want.stored_length, rsp_ch.stored_length);
						err_cnt++;
					end
					if (rsp_ch.truncated !== want.truncated) begin
						$error("truncated: expected %0b, got %0b", want.truncated,
							rsp_ch.truncated);
						err_cnt++;
					end
					if (rsp_ch.produced_total !== want.produced_total) begin
						$error("produced_total: expected %0d, got %0d",
							want.produced_total, rsp_ch.produced_total);
						err_cnt++;
					end
				end
				rcv_stall = pick_gap(rcv_calm);
			end
			if (long_hold) begin
				rsp_ch.ready <= 1'b0;
			end else if (rcv_stall > 0) begin
				rcv_stall--;
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("[head_tail_capture_buffer_unit] ERROR");
			$finish;
		end
	end

	// Long hold-off: once the random part is well under way and the sender has
	// plenty queued, the receiver stops taking results so the block fills up
	// and drops req.ready while items keep being offered.
	initial begin
		long_hold = 1'b0;
		while (accepted_cnt < 500 || req_backlog.size() < 40)
			@(negedge clk);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	task automatic queue_item(logic mode, logic [htcb_pkg::BYTE_W-1:0] b,
		logic [htcb_pkg::POS_W-1:0] pos);
		capture_req_t it;
		it.mode = mode;
		it.data_byte = b;
		it.position = pos;
		req_backlog.push_back(it);
	endtask

	// Wait until every item is taken and every result is in, then let the
	// pipeline go quiet before touching the limit register.
	task automatic drain();
		while (req_backlog.size() != 0 || req_ch.valid || rsp_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// A limit write also empties the capture and zeroes the byte count.
	task automatic write_limit(logic [htcb_pkg::LIMIT_W-1:0] value);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		limit_reg = value;
		head_cnt = 0;
		tail_cnt = 0;
		tail_oldest = 0;
		produced_cnt = '0;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// Random appends and reads under the current limit. Reads mostly land
	// inside the capture, some just past its end, the rest anywhere.
	task automatic random_phase(int unsigned n);
		int unsigned lim, appends, len, pos, roll;
		lim = (limit_reg > htcb_pkg::MAX_BYTES) ? htcb_pkg::MAX_BYTES : limit_reg;
		appends = 0;
		for (int unsigned i = 0; i < n; i++) begin
			len = (appends < lim) ? appends : lim;
			if ($urandom_range(0, 99) < 55) begin
				queue_item(htcb_pkg::MODE_APPEND,
					htcb_pkg::BYTE_W'($urandom_range(0, 255)),
					htcb_pkg::POS_W'($urandom_range(0, 4095)));
				appends++;
			end else begin
				roll = $urandom_range(0, 9);
				if (roll < 6)
					pos = $urandom_range(0, len);
				else if (roll < 8)
					pos = len + $urandom_range(0, 2);
				else
					pos = $urandom_range(0, 4095);
				if (pos > 4095)
					pos = 4095;
				queue_item(htcb_pkg::MODE_READ, htcb_pkg::BYTE_W'($urandom_range(0, 255)),
					htcb_pkg::POS_W'(pos));
			end
		end
	endtask

	initial begin
		int unsigned rand_items, roll, n;
		logic [htcb_pkg::LIMIT_W-1:0] lim;

		// every input known from time zero
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req_ch.valid = 1'b0;
		req_ch.mode = htcb_pkg::MODE_APPEND;
		req_ch.data_byte = '0;
		req_ch.position = '0;
		rsp_ch.ready = 1'b0;
		drv_gap = 0;
		drv_calm = 0;
		rcv_stall = 0;
		rcv_calm = 0;
		accepted_cnt = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		rand_items = 0;

		// reset state: full 4096-byte limit, empty capture
		limit_reg = htcb_pkg::LIMIT_W'(htcb_pkg::MAX_BYTES);
		head_cnt = 0;
		tail_cnt = 0;
		tail_oldest = 0;
		produced_cnt = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: default limit; read of an empty capture, byte extremes,
		// reads inside, at and far beyond the stored length.
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h00, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'hFF, 12'hFFF);
		queue_item(htcb_pkg::MODE_APPEND, 8'hA5, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'hFF, 12'd2);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd3);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'hFFF);
		drain();

		// zero limit: nothing kept but bytes still counted, so truncated
		write_limit(13'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h5A, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'hC3, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		drain();

		// limit of one: no head, single-byte ring keeps the newest byte
		write_limit(13'd1);
		queue_item(htcb_pkg::MODE_APPEND, 8'h11, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h22, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd1);
		drain();

		// all-ones limit saturates to the maximum
		write_limit(13'h1FFF);
		queue_item(htcb_pkg::MODE_APPEND, 8'h80, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		drain();

		// limit of three: one head byte, two-byte ring that wraps
		write_limit(13'd3);
		queue_item(htcb_pkg::MODE_APPEND, 8'h01, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h02, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h03, 12'd0);
		queue_item(htcb_pkg::MODE_APPEND, 8'h04, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd0);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd1);
		queue_item(htcb_pkg::MODE_READ, 8'h00, 12'd2);
		drain();

		// Random phases: mostly small limits so the ring wraps many times,
		// some mid-sized, a few arbitrary 13-bit values, the largest and zero.
		while (rand_items < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll < 12)
				lim = htcb_pkg::LIMIT_W'($urandom_range(1, 48));
			else if (roll < 15)
				lim = htcb_pkg::LIMIT_W'($urandom_range(49, 600));
			else if (roll < 18)
				lim = htcb_pkg::LIMIT_W'($urandom_range(0, 8191));
			else if (roll == 18)
				lim = htcb_pkg::LIMIT_W'(htcb_pkg::MAX_BYTES);
			else
				lim = '0;
			n = $urandom_range(60, 180);
			write_limit(lim);
			random_phase(n);
			drain();
			rand_items += n;
		end

		if (err_cnt == 0 && rsp_due.size() == 0) begin
			$display("[head_tail_capture_buffer_unit] OK");
		end else begin
			$display("[head_tail_capture_buffer_unit] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
+incdir+rtl
rtl/htcb_pkg.sv
rtl/htcb_in_if.sv
rtl/htcb_out_if.sv
rtl/htcb_ram.sv
rtl/htcb_ctrl.sv
rtl/htcb_dp.sv
rtl/head_tail_capture_buffer_unit.sv
sim/testbench.sv
